// File: src/bvs_pkg.sv
package bvs_pkg;

  localparam int unsigned DIM_MAX_DEF = 64;
  localparam int unsigned BRICK_X_DEF = 8;
  localparam int unsigned BRICK_Y_DEF = 8;
  localparam int unsigned BRICK_Z_DEF = 8;

  localparam int unsigned COORD_W  = 6;
  localparam int unsigned COORD_N  = 64;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned QDEPTH   = 2;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_BRICK  = 3'd3,
    OP_GLOBAL = 3'd4
  } op_code_t;

  typedef enum logic [2:0] {
    K_CLEAR,
    K_WRITE,
    K_READ,
    K_BRICK,
    K_GLOBAL,
    K_NONE
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    B_SWEEP,
    B_IDLE,
    B_EXEC
  } back_state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef struct packed {
    logic sweeping;
    logic exec;
  } bk_stat_t;

  function automatic int unsigned idx_w(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Coordinates never exceed the port range, whatever the store's nominal extent.
  function automatic int unsigned coord_dim(input int unsigned d);
    return (d < COORD_N) ? d : COORD_N;
  endfunction

endpackage

// File: src/bricked_volume_store_minmax.sv
// Port group   Direction  Handshake            Payload
// in_*         input      in_valid / in_stall  op, coord_x/y/z, sample
// out_*        output     out_valid / out_stall read_value, max_value, is_constant, status
// APB          input      psel, penable, pwrite paddr, pwdata, prdata (pready tied high)
//
// In the back end each item is handled in two steps: the voxel and brick memories are
// read as it is popped, then the execute state updates them on a write and loads the result register.
// A clear item is followed by a sweep of the brick fill memory, one entry per
// cycle, covering all 512 entries with the default brick layout; the same sweep runs after reset.
// in_stall is high during a sweep and while the two-entry item queue is full.
// The result register lets the next item be queued while a result waits on out_stall.
module bricked_volume_store_minmax import bvs_pkg::*; #(
  parameter int unsigned DIM_MAX = DIM_MAX_DEF,
  parameter int unsigned BRICK_X = BRICK_X_DEF,
  parameter int unsigned BRICK_Y = BRICK_Y_DEF,
  parameter int unsigned BRICK_Z = BRICK_Z_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_op,
  input  logic [COORD_W-1:0]         in_coord_x,
  input  logic [COORD_W-1:0]         in_coord_y,
  input  logic [COORD_W-1:0]         in_coord_z,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_read_value,
  output logic signed [SAMPLE_W-1:0] out_max_value,
  output logic                       out_is_constant,
  output logic [1:0]                 out_status,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned CD     = coord_dim(DIM_MAX);
  localparam int unsigned CW     = idx_w(CD);
  localparam int unsigned NBX    = (CD + BRICK_X - 1) / BRICK_X;
  localparam int unsigned NBY    = (CD + BRICK_Y - 1) / BRICK_Y;
  localparam int unsigned NBZ    = (CD + BRICK_Z - 1) / BRICK_Z;
  localparam int unsigned BRK_AW = idx_w(NBX) + idx_w(NBY) + idx_w(NBZ);
  localparam int unsigned VOX_AW = 3 * CW;
  localparam int unsigned ENT_W  = $bits(op_kind_t) + 1 + BRK_AW + VOX_AW + SAMPLE_W;

  cfg_t             cfg_r, cfg_nxt;
  logic             cfg_we;
  q_stat_t          q_stat;
  bk_stat_t         bk_stat;
  logic             q_push, q_pop;
  logic [ENT_W-1:0] q_push_data, q_head;

  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (paddr[3:2])
        REG_SIZE_X: cfg_nxt.size_x = pwdata[SIZE_W-1:0];
        REG_SIZE_Y: cfg_nxt.size_y = pwdata[SIZE_W-1:0];
        REG_SIZE_Z: cfg_nxt.size_z = pwdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = 32'(cfg_r.size_x);
      REG_SIZE_Y: prdata = 32'(cfg_r.size_y);
      REG_SIZE_Z: prdata = 32'(cfg_r.size_z);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x <= SIZE_W'(COORD_N);
      cfg_r.size_y <= SIZE_W'(COORD_N);
      cfg_r.size_z <= SIZE_W'(COORD_N);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bvs_front #(
    .DIM_MAX (DIM_MAX),
    .BRICK_X (BRICK_X),
    .BRICK_Y (BRICK_Y),
    .BRICK_Z (BRICK_Z),
    .ENT_W   (ENT_W)
  ) u_front (
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .bk_stat    (bk_stat),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_coord_z (in_coord_z),
    .in_sample  (in_sample),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  bvs_fifo #(
    .W (ENT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  bvs_back #(
    .DIM_MAX (DIM_MAX),
    .BRICK_X (BRICK_X),
    .BRICK_Y (BRICK_Y),
    .BRICK_Z (BRICK_Z),
    .ENT_W   (ENT_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head            (q_head),
    .pop             (q_pop),
    .bk_stat         (bk_stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_max_value   (out_max_value),
    .out_is_constant (out_is_constant),
    .out_status      (out_status)
  );

  // An item leaves the queue only when the result register will be free for it.
  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid || !out_stall))
    else $error("item popped while the result register is held");

  a_no_pop_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.sweeping |-> !q_pop)
    else $error("item popped during a fill sweep");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.exec |=> out_valid)
    else $error("executed item produced no result");

endmodule

// File: src/bvs_fifo.sv
module bvs_fifo import bvs_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output q_stat_t      q_stat
);

  localparam int unsigned PW    = idx_w(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  logic [W-1:0]     slot_r [QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head            = slot_r[rd_ptr_r];
  assign q_stat.full     = (cnt_r == CNT_W'(QDEPTH));
  assign q_stat.nonempty = (cnt_r != '0);

endmodule

// File: src/bvs_front.sv
module bvs_front import bvs_pkg::*; #(
  parameter int unsigned DIM_MAX = DIM_MAX_DEF,
  parameter int unsigned BRICK_X = BRICK_X_DEF,
  parameter int unsigned BRICK_Y = BRICK_Y_DEF,
  parameter int unsigned BRICK_Z = BRICK_Z_DEF,
  parameter int unsigned ENT_W   = 8
) (
  input  cfg_t                       cfg,
  input  q_stat_t                    q_stat,
  input  bk_stat_t                   bk_stat,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_op,
  input  logic [COORD_W-1:0]         in_coord_x,
  input  logic [COORD_W-1:0]         in_coord_y,
  input  logic [COORD_W-1:0]         in_coord_z,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       push,
  output logic [ENT_W-1:0]           push_data
);

  localparam int unsigned CD     = coord_dim(DIM_MAX);
  localparam int unsigned CW     = idx_w(CD);
  localparam int unsigned NBX    = (CD + BRICK_X - 1) / BRICK_X;
  localparam int unsigned NBY    = (CD + BRICK_Y - 1) / BRICK_Y;
  localparam int unsigned NBZ    = (CD + BRICK_Z - 1) / BRICK_Z;
  localparam int unsigned BXW    = idx_w(NBX);
  localparam int unsigned BYW    = idx_w(NBY);
  localparam int unsigned BZW    = idx_w(NBZ);
  localparam int unsigned BRK_AW = BXW + BYW + BZW;
  localparam int unsigned VOX_AW = 3 * CW;
  localparam logic [8:0]  DIM_LIM = 9'(DIM_MAX);

  typedef struct packed {
    op_kind_t                   kind;
    logic                       vol_ok;
    logic [BRK_AW-1:0]          brick;
    logic [VOX_AW-1:0]          vaddr;
    logic signed [SAMPLE_W-1:0] sample;
  } entry_t;

  logic [BXW-1:0] bx_tab [COORD_N];
  logic [BYW-1:0] by_tab [COORD_N];
  logic [BZW-1:0] bz_tab [COORD_N];
  entry_t         ent;
  logic           in_x, in_y, in_z;

  // Brick index along each axis comes from small constant tables.
  for (genvar i = 0; i < COORD_N; i++) begin : g_tab
    localparam int unsigned BXV = i / BRICK_X;
    localparam int unsigned BYV = i / BRICK_Y;
    localparam int unsigned BZV = i / BRICK_Z;
    assign bx_tab[i] = BXW'(BXV);
    assign by_tab[i] = BYW'(BYV);
    assign bz_tab[i] = BZW'(BZV);
  end

  assign in_x = (SIZE_W'(in_coord_x) < cfg.size_x) && (9'(in_coord_x) < DIM_LIM);
  assign in_y = (SIZE_W'(in_coord_y) < cfg.size_y) && (9'(in_coord_y) < DIM_LIM);
  assign in_z = (SIZE_W'(in_coord_z) < cfg.size_z) && (9'(in_coord_z) < DIM_LIM);

  always_comb begin
    case (in_op)
      OP_CLEAR:  ent.kind = K_CLEAR;
      OP_WRITE:  ent.kind = K_WRITE;
      OP_READ:   ent.kind = K_READ;
      OP_BRICK:  ent.kind = K_BRICK;
      OP_GLOBAL: ent.kind = K_GLOBAL;
      default:   ent.kind = K_NONE;
    endcase
    ent.vol_ok = in_x && in_y && in_z;
    ent.brick  = {bz_tab[in_coord_z], by_tab[in_coord_y], bx_tab[in_coord_x]};
    ent.vaddr  = {CW'(in_coord_z), CW'(in_coord_y), CW'(in_coord_x)};
    ent.sample = in_sample;
  end

  assign in_stall  = q_stat.full || bk_stat.sweeping;
  assign push      = in_valid && !in_stall;
  assign push_data = ENT_W'(ent);

endmodule

// File: src/bvs_back.sv
module bvs_back import bvs_pkg::*; #(
  parameter int unsigned DIM_MAX = DIM_MAX_DEF,
  parameter int unsigned BRICK_X = BRICK_X_DEF,
  parameter int unsigned BRICK_Y = BRICK_Y_DEF,
  parameter int unsigned BRICK_Z = BRICK_Z_DEF,
  parameter int unsigned ENT_W   = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  q_stat_t                    q_stat,
  input  logic [ENT_W-1:0]           head,
  output logic                       pop,
  output bk_stat_t                   bk_stat,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_read_value,
  output logic signed [SAMPLE_W-1:0] out_max_value,
  output logic                       out_is_constant,
  output logic [1:0]                 out_status
);

  localparam int unsigned CD        = coord_dim(DIM_MAX);
  localparam int unsigned CW        = idx_w(CD);
  localparam int unsigned NBX       = (CD + BRICK_X - 1) / BRICK_X;
  localparam int unsigned NBY       = (CD + BRICK_Y - 1) / BRICK_Y;
  localparam int unsigned NBZ       = (CD + BRICK_Z - 1) / BRICK_Z;
  localparam int unsigned BRK_AW    = idx_w(NBX) + idx_w(NBY) + idx_w(NBZ);
  localparam int unsigned VOX_AW    = 3 * CW;
  localparam int unsigned VOX_DEPTH = 2 ** VOX_AW;
  localparam int unsigned BRK_DEPTH = 2 ** BRK_AW;

  typedef struct packed {
    op_kind_t                   kind;
    logic                       vol_ok;
    logic [BRK_AW-1:0]          brick;
    logic [VOX_AW-1:0]          vaddr;
    logic signed [SAMPLE_W-1:0] sample;
  } entry_t;

  typedef struct packed {
    logic                filled;
    logic [SAMPLE_W-1:0] min_v;
    logic [SAMPLE_W-1:0] max_v;
  } brk_ent_t;

  logic [SAMPLE_W-1:0] vox_mem [VOX_DEPTH];
  brk_ent_t            brk_mem [BRK_DEPTH];

  back_state_t         state_r, state_nxt;
  logic [BRK_AW-1:0]   sweep_cnt_r, sweep_cnt_nxt;
  logic                any_r, any_nxt;
  logic [SAMPLE_W-1:0] gmin_r, gmin_nxt;
  logic [SAMPLE_W-1:0] gmax_r, gmax_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] rv_r, rv_nxt;
  logic [SAMPLE_W-1:0] mv_r, mv_nxt;
  logic                cst_r, cst_nxt;
  status_t             st_r, st_nxt;
  entry_t              cur_r;
  logic [SAMPLE_W-1:0] vox_rd_r;
  brk_ent_t            brk_rd_r;

  entry_t              head_e;
  logic                vox_we;
  logic                brk_we;
  logic [BRK_AW-1:0]   brk_waddr;
  brk_ent_t            brk_wdata;

  assign head_e = entry_t'(head);
  assign pop    = (state_r == B_IDLE) && q_stat.nonempty && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    any_nxt       = any_r;
    gmin_nxt      = gmin_r;
    gmax_nxt      = gmax_r;
    out_valid_nxt = out_valid_r && out_stall;
    rv_nxt        = rv_r;
    mv_nxt        = mv_r;
    cst_nxt       = cst_r;
    st_nxt        = st_r;
    vox_we        = 1'b0;
    brk_we        = 1'b0;
    brk_waddr     = cur_r.brick;
    brk_wdata     = '0;
    case (state_r)
      B_SWEEP: begin
        brk_we        = 1'b1;
        brk_waddr     = sweep_cnt_r;
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == '1) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop) begin
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        state_nxt     = B_IDLE;
        out_valid_nxt = 1'b1;
        rv_nxt        = '0;
        mv_nxt        = '0;
        cst_nxt       = 1'b0;
        st_nxt        = ST_OK;
        case (cur_r.kind)
          K_CLEAR: begin
            // Fill flags are wiped by a sweep; the counter has wrapped back to zero.
            any_nxt   = 1'b0;
            gmin_nxt  = '0;
            gmax_nxt  = '0;
            state_nxt = B_SWEEP;
          end
          K_WRITE: begin
            if (!cur_r.vol_ok) begin
              st_nxt = ST_OUTSIDE;
            end else begin
              vox_we           = 1'b1;
              brk_we           = 1'b1;
              brk_wdata.filled = 1'b1;
              if (!brk_rd_r.filled) begin
                brk_wdata.min_v = cur_r.sample;
                brk_wdata.max_v = cur_r.sample;
              end else begin
                brk_wdata.min_v = ($signed(cur_r.sample) < $signed(brk_rd_r.min_v)) ?
                                  cur_r.sample : brk_rd_r.min_v;
                brk_wdata.max_v = ($signed(cur_r.sample) > $signed(brk_rd_r.max_v)) ?
                                  cur_r.sample : brk_rd_r.max_v;
              end
              any_nxt = 1'b1;
              if (!any_r) begin
                gmin_nxt = cur_r.sample;
                gmax_nxt = cur_r.sample;
              end else begin
                if ($signed(cur_r.sample) < $signed(gmin_r)) begin
                  gmin_nxt = cur_r.sample;
                end
                if ($signed(cur_r.sample) > $signed(gmax_r)) begin
                  gmax_nxt = cur_r.sample;
                end
              end
            end
          end
          K_READ: begin
            if (!cur_r.vol_ok) begin
              st_nxt = ST_OUTSIDE;
            end else if (!brk_rd_r.filled) begin
              st_nxt = ST_EMPTY;
            end else begin
              rv_nxt = vox_rd_r;
            end
          end
          K_BRICK: begin
            if (!cur_r.vol_ok) begin
              st_nxt = ST_OUTSIDE;
            end else if (!brk_rd_r.filled) begin
              st_nxt = ST_EMPTY;
            end else begin
              rv_nxt  = brk_rd_r.min_v;
              mv_nxt  = brk_rd_r.max_v;
              cst_nxt = (brk_rd_r.min_v == brk_rd_r.max_v);
            end
          end
          K_GLOBAL: begin
            if (!any_r) begin
              st_nxt = ST_EMPTY;
            end else begin
              rv_nxt  = gmin_r;
              mv_nxt  = gmax_r;
              cst_nxt = (gmin_r == gmax_r);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_SWEEP;
      sweep_cnt_r <= '0;
      any_r       <= 1'b0;
      gmin_r      <= '0;
      gmax_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      any_r       <= any_nxt;
      gmin_r      <= gmin_nxt;
      gmax_r      <= gmax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rv_r  <= rv_nxt;
    mv_r  <= mv_nxt;
    cst_r <= cst_nxt;
    st_r  <= st_nxt;
    if (pop) begin
      cur_r <= head_e;
    end
  end

  always_ff @(posedge clk) begin
    if (vox_we) begin
      vox_mem[cur_r.vaddr] <= cur_r.sample;
    end
    if (pop) begin
      vox_rd_r <= vox_mem[head_e.vaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (brk_we) begin
      brk_mem[brk_waddr] <= brk_wdata;
    end
    if (pop) begin
      brk_rd_r <= brk_mem[head_e.brick];
    end
  end

  assign bk_stat.sweeping = (state_r == B_SWEEP);
  assign bk_stat.exec     = (state_r == B_EXEC);
  assign out_valid        = out_valid_r;
  assign out_read_value   = rv_r;
  assign out_max_value    = mv_r;
  assign out_is_constant  = cst_r;
  assign out_status       = st_r;

endmodule
